@@ rtl/mlpf_pkg.sv @@
package mlpf_pkg;

  localparam int unsigned MAX_LAYERS  = 4;
  localparam int unsigned MAX_WIDTH   = 16;
  localparam int unsigned SIG_ENTRIES = 256;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned NUM_WREGS   = MAX_LAYERS + 1;

  localparam int unsigned LAY_W   = $clog2(MAX_LAYERS);
  localparam int unsigned IDX_W   = $clog2(MAX_WIDTH);
  localparam int unsigned CNT_W   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned NL_W    = $clog2(MAX_LAYERS + 1);
  localparam int unsigned SIG_W   = $clog2(SIG_ENTRIES);
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned ACT_W   = 13;
  localparam int unsigned PROD_W  = 32;
  localparam int unsigned ACC_W   = 37;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 5;

  typedef enum logic [1:0] {
    OP_LOAD_W = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_LOAD_A = 2'd2,
    OP_RUN    = 2'd3
  } cmd_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LAYER_COUNT = 3'd0,
    CFG_WIDTH_L0    = 3'd1,
    CFG_WIDTH_L1    = 3'd2,
    CFG_WIDTH_L2    = 3'd3,
    CFG_WIDTH_L3    = 3'd4,
    CFG_WIDTH_L4    = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_BIAS,
    B_MAC,
    B_DRAIN,
    B_ACT
  } back_state_e;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [1:0]        layer_sel;
    logic [3:0]        row_sel;
    logic [3:0]        col_sel;
    logic signed [15:0] load_value;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  out_index;
    logic [12:0] out_value;
    logic        out_last;
  } out_item_t;

  typedef struct packed {
    cmd_op_e          op;
    logic [LAY_W-1:0] layer;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
  } cmd_t;

  // clamped configuration seen by the engine
  typedef struct packed {
    logic [NL_W-1:0]                  num_layers;
    logic [NUM_WREGS-1:0][CNT_W-1:0]  widths;
  } cfg_t;

  typedef logic [SIG_ENTRIES-1:0][ACT_W-1:0] sig_rom_t;

  localparam longint unsigned Q30_ONE = 64'd1 << 30;

  function automatic longint unsigned exp_neg_q30(longint unsigned t);
    longint unsigned u, u2, u3, u4, y;
    u  = t << 10;
    u2 = (u * u) >> 30;
    u3 = (u2 * u) >> 30;
    u4 = (u3 * u) >> 30;
    y  = Q30_ONE - u + u2 / 2 - u3 / 6 + u4 / 24;
    for (int n = 0; n < 8; n++) begin
      y = (y * y) >> 30;
    end
    return y;
  endfunction

  // restoring long division, used only while building the table
  function automatic longint unsigned udiv_u64(longint unsigned n, longint unsigned d);
    longint unsigned q, r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // elaboration-time sigmoid table over bin midpoints of [-8,8)
  function automatic sig_rom_t build_sig_rom();
    sig_rom_t rom;
    longint m;
    longint unsigned t, e, den, num;
    for (int i = 0; i < SIG_ENTRIES; i++) begin
      m   = -32768 + longint'((longint'(2 * i + 1) * 65536) / (2 * SIG_ENTRIES));
      t   = (m < 0) ? longint'(-m) : longint'(m);
      e   = exp_neg_q30(t);
      den = Q30_ONE + e;
      num = (m >= 0) ? Q30_ONE : e;
      rom[i] = ACT_W'(udiv_u64((num << 12) + (den >> 1), den));
    end
    return rom;
  endfunction

endpackage

@@ rtl/mlp_sigmoid_forward.sv @@
// Fixed-point forward pass of a fully connected sigmoid network. Items carry an
// opcode: load weight, load bias and load input each write one Q3.12 word into the
// weight, bias or input store and give no result; run walks the layers in use and
// emits one item per output neuron (index, Q0.12 activation, last flag). A front
// stage takes and decodes items into a two-entry command queue, so loads keep
// flowing in while the engine is busy; while idle, the engine retires one load per
// cycle. A run goes neuron by neuron through the single multiply-accumulate unit
// with its one read port per store; a finished output waits behind a stalled one.
// Configuration registers are to be written only while idle; the block itself does
// not enforce it.
module mlp_sigmoid_forward (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  mlpf_pkg::in_item_t                   in_item_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output mlpf_pkg::out_item_t                  out_item_o,
  input  logic                                 cfg_we_i,
  input  logic [mlpf_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [mlpf_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned NL_W  = mlpf_pkg::NL_W;
  localparam int unsigned CNT_W = mlpf_pkg::CNT_W;

  // raw register contents, clamped below
  logic [2:0]                    layer_count_q;
  logic [mlpf_pkg::NUM_WREGS-1:0][4:0] width_q;
  mlpf_pkg::cfg_t                cfg;

  logic           push_valid, push_ready, pop_valid, pop;
  mlpf_pkg::cmd_t push_cmd, pop_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer_count_q <= 3'd1;
      for (int i = 0; i < mlpf_pkg::NUM_WREGS; i++) begin
        width_q[i] <= 5'd1;
      end
    end else if (cfg_we_i) begin
      unique case (mlpf_pkg::cfg_idx_e'(cfg_idx_i))
        mlpf_pkg::CFG_LAYER_COUNT: layer_count_q <= cfg_data_i[2:0];
        mlpf_pkg::CFG_WIDTH_L0:    width_q[0]    <= cfg_data_i;
        mlpf_pkg::CFG_WIDTH_L1:    width_q[1]    <= cfg_data_i;
        mlpf_pkg::CFG_WIDTH_L2:    width_q[2]    <= cfg_data_i;
        mlpf_pkg::CFG_WIDTH_L3:    width_q[3]    <= cfg_data_i;
        mlpf_pkg::CFG_WIDTH_L4:    width_q[4]    <= cfg_data_i;
        default: ;  // indexes past the list are dropped
      endcase
    end
  end

  // saturate layer count and widths into their legal ranges
  always_comb begin
    if (layer_count_q == '0) begin
      cfg.num_layers = NL_W'(1);
    end else if (layer_count_q > 3'(mlpf_pkg::MAX_LAYERS)) begin
      cfg.num_layers = NL_W'(mlpf_pkg::MAX_LAYERS);
    end else begin
      cfg.num_layers = NL_W'(layer_count_q);
    end
    for (int i = 0; i < mlpf_pkg::NUM_WREGS; i++) begin
      if (width_q[i] == '0) begin
        cfg.widths[i] = CNT_W'(1);
      end else if (width_q[i] > 5'(mlpf_pkg::MAX_WIDTH)) begin
        cfg.widths[i] = CNT_W'(mlpf_pkg::MAX_WIDTH);
      end else begin
        cfg.widths[i] = CNT_W'(width_q[i]);
      end
    end
  end

  // front: take and decode items
  mlpf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  // decoupling queue between front and engine
  mlpf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_cmd_o    (pop_cmd)
  );

  // engine: stores, multiply-accumulate, sigmoid table, output register
  mlpf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_valid_i (pop_valid),
    .cmd_pop_o   (pop),
    .cmd_i       (pop_cmd),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

@@ rtl/mlpf_front.sv @@
module mlpf_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mlpf_pkg::in_item_t in_item_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output mlpf_pkg::cmd_t     push_cmd_o
);

  logic           cmd_valid_q, cmd_valid_d;
  mlpf_pkg::cmd_t cmd_q, cmd_d;
  logic           accept;

  assign in_stall_o   = cmd_valid_q && !push_ready_i;
  assign accept       = in_valid_i && !in_stall_o;
  assign push_valid_o = cmd_valid_q;
  assign push_cmd_o   = cmd_q;

  // decode the raw item into an engine command
  always_comb begin
    cmd_d       = cmd_q;
    cmd_valid_d = cmd_valid_q;
    if (cmd_valid_q && push_ready_i) begin
      cmd_valid_d = 1'b0;
    end
    if (accept) begin
      cmd_valid_d = 1'b1;
      cmd_d.op    = mlpf_pkg::cmd_op_e'(in_item_i.opcode);
      cmd_d.layer = in_item_i.layer_sel;
      cmd_d.row   = in_item_i.row_sel;
      cmd_d.col   = in_item_i.col_sel;
      cmd_d.value = in_item_i.load_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
    end else begin
      cmd_valid_q <= cmd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

endmodule

@@ rtl/mlpf_queue.sv @@
module mlpf_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  mlpf_pkg::cmd_t push_cmd_i,
  output logic           pop_valid_o,
  input  logic           pop_i,
  output mlpf_pkg::cmd_t pop_cmd_o
);

  localparam int unsigned PTR_W = $clog2(mlpf_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(mlpf_pkg::QUEUE_DEPTH + 1);

  mlpf_pkg::cmd_t         slots_q [mlpf_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic                   do_push, do_pop;

  assign push_ready_o = (count_q != CNT_W'(mlpf_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_cmd_o    = slots_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(mlpf_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(mlpf_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

@@ rtl/mlpf_back.sv @@
module mlpf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mlpf_pkg::cfg_t      cfg_i,
  input  logic                cmd_valid_i,
  output logic                cmd_pop_o,
  input  mlpf_pkg::cmd_t      cmd_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mlpf_pkg::out_item_t out_item_o
);

  localparam int unsigned LAY_W  = mlpf_pkg::LAY_W;
  localparam int unsigned IDX_W  = mlpf_pkg::IDX_W;
  localparam int unsigned CNT_W  = mlpf_pkg::CNT_W;
  localparam int unsigned NL_W   = mlpf_pkg::NL_W;
  localparam int unsigned VAL_W  = mlpf_pkg::VAL_W;
  localparam int unsigned ACT_W  = mlpf_pkg::ACT_W;
  localparam int unsigned ACC_W  = mlpf_pkg::ACC_W;
  localparam int unsigned SIG_W  = mlpf_pkg::SIG_W;
  localparam int unsigned WA_W   = LAY_W + 2 * IDX_W;
  localparam int unsigned BA_W   = LAY_W + IDX_W;
  localparam int unsigned AA_W   = 2 + IDX_W;
  localparam int unsigned S_W    = ACC_W - 12;

  localparam mlpf_pkg::sig_rom_t SigRom = mlpf_pkg::build_sig_rom();

  logic [VAL_W-1:0] w_mem [2**WA_W];
  logic [VAL_W-1:0] b_mem [2**BA_W];
  logic [VAL_W-1:0] a_mem [2**AA_W];

  mlpf_pkg::back_state_e state_q, state_d;
  logic [LAY_W-1:0] l_q, l_d;
  logic [IDX_W-1:0] j_q, j_d, k_q, k_d;

  logic [VAL_W-1:0] w_rd_q, b_rd_q, a_rd_q;
  logic             rdv_q, pv_q, bias_v_q;
  logic signed [mlpf_pkg::PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]            acc_q;

  logic               w_we, b_we, a_we;
  logic [WA_W-1:0]    w_waddr;
  logic [BA_W-1:0]    b_waddr;
  logic [AA_W-1:0]    a_waddr, a_raddr;
  logic [VAL_W-1:0]   a_wdata;
  logic               mac_issue, bias_issue;
  logic [1:0]         src_bank, dst_bank;
  logic [CNT_W-1:0]   prev_w, cur_w;
  logic               last_layer, last_neuron, last_tap;
  logic               out_free;
  logic               out_valid_q, out_valid_d;
  mlpf_pkg::out_item_t out_q, out_d;

  logic signed [S_W-1:0] s_full;
  logic [VAL_W-1:0]      s_sat;
  logic [SIG_W-1:0]      sig_idx;
  logic [ACT_W-1:0]      sig_val;

  assign prev_w      = cfg_i.widths[{1'b0, l_q}];
  assign cur_w       = cfg_i.widths[(LAY_W + 1)'(l_q) + 1'b1];
  assign last_layer  = (NL_W'(l_q) == cfg_i.num_layers - 1'b1);
  assign last_neuron = (CNT_W'(j_q) == cur_w - 1'b1);
  assign last_tap    = (CNT_W'(k_q) == prev_w - 1'b1);
  assign src_bank    = (l_q == '0) ? 2'd0 : (l_q[0] ? 2'd1 : 2'd2);
  assign dst_bank    = l_q[0] ? 2'd2 : 2'd1;
  assign mac_issue   = (state_q == mlpf_pkg::B_MAC);
  assign bias_issue  = (state_q == mlpf_pkg::B_BIAS);
  assign a_raddr     = {src_bank, k_q};
  assign out_free    = !out_valid_q || !out_stall_i;

  // floor of the sum in Q3.12, saturated, then the top bits pick a bin
  always_comb begin
    s_full = acc_q[ACC_W-1:12];
    if (s_full > S_W'(32767)) begin
      s_sat = 16'h7fff;
    end else if (s_full < -S_W'(32768)) begin
      s_sat = 16'h8000;
    end else begin
      s_sat = s_full[VAL_W-1:0];
    end
    sig_idx = {~s_sat[VAL_W-1], s_sat[VAL_W-2 -: (SIG_W-1)]};
    sig_val = SigRom[sig_idx];
  end

  always_comb begin
    state_d     = state_q;
    l_d         = l_q;
    j_d         = j_q;
    k_d         = k_q;
    cmd_pop_o   = 1'b0;
    w_we        = 1'b0;
    b_we        = 1'b0;
    a_we        = 1'b0;
    w_waddr     = {cmd_i.layer, cmd_i.row, cmd_i.col};
    b_waddr     = {cmd_i.layer, cmd_i.col};
    a_waddr     = {2'd0, cmd_i.col};
    a_wdata     = cmd_i.value;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      mlpf_pkg::B_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.op)
            mlpf_pkg::OP_LOAD_W: w_we = 1'b1;
            mlpf_pkg::OP_LOAD_B: b_we = 1'b1;
            mlpf_pkg::OP_LOAD_A: a_we = 1'b1;
            mlpf_pkg::OP_RUN: begin
              l_d     = '0;
              j_d     = '0;
              state_d = mlpf_pkg::B_BIAS;
            end
          endcase
        end
      end
      mlpf_pkg::B_BIAS: begin
        k_d     = '0;
        state_d = mlpf_pkg::B_MAC;
      end
      mlpf_pkg::B_MAC: begin
        k_d = k_q + 1'b1;
        if (last_tap) begin
          state_d = mlpf_pkg::B_DRAIN;
        end
      end
      mlpf_pkg::B_DRAIN: begin
        if (!rdv_q && !pv_q) begin
          state_d = mlpf_pkg::B_ACT;
        end
      end
      mlpf_pkg::B_ACT: begin
        if (!last_layer || out_free) begin
          if (last_layer) begin
            out_valid_d     = 1'b1;
            out_d.out_index = 4'(j_q);
            out_d.out_value = sig_val;
            out_d.out_last  = last_neuron;
          end else begin
            a_we    = 1'b1;
            a_waddr = {dst_bank, j_q};
            a_wdata = VAL_W'(sig_val);
          end
          if (last_neuron) begin
            j_d = '0;
            if (last_layer) begin
              state_d = mlpf_pkg::B_IDLE;
            end else begin
              l_d     = l_q + 1'b1;
              state_d = mlpf_pkg::B_BIAS;
            end
          end else begin
            j_d     = j_q + 1'b1;
            state_d = mlpf_pkg::B_BIAS;
          end
        end
      end
      default: state_d = mlpf_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mlpf_pkg::B_IDLE;
      l_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      rdv_q       <= 1'b0;
      pv_q        <= 1'b0;
      bias_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      l_q         <= l_d;
      j_q         <= j_d;
      k_q         <= k_d;
      rdv_q       <= mac_issue;
      pv_q        <= rdv_q;
      bias_v_q    <= bias_issue;
      out_valid_q <= out_valid_d;
    end
  end

  // memories with registered read data
  always_ff @(posedge clk_i) begin
    if (w_we) begin
      w_mem[w_waddr] <= cmd_i.value;
    end
    if (mac_issue) begin
      w_rd_q <= w_mem[{l_q, k_q, j_q}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_we) begin
      b_mem[b_waddr] <= cmd_i.value;
    end
    if (bias_issue) begin
      b_rd_q <= b_mem[{l_q, j_q}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_we) begin
      a_mem[a_waddr] <= a_wdata;
    end
    if (mac_issue) begin
      a_rd_q <= a_mem[a_raddr];
    end
  end

  // multiply, then accumulate
  always_ff @(posedge clk_i) begin
    prod_q <= $signed(a_rd_q) * $signed(w_rd_q);
    if (bias_v_q) begin
      acc_q <= {{(ACC_W-VAL_W-12){b_rd_q[VAL_W-1]}}, b_rd_q, 12'b0};
    end else if (pv_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

@@ bench/tb_mlp_sigmoid_forward.sv @@
`timescale 1ns / 100ps

module tb_mlp_sigmoid_forward;

  // golden forward-pass model: keeps its own copy of the stores and registers
  // and queues the output items that each accepted input item should cause
  class forward_pass_model;
    shortint       wts [1024];
    shortint       biases [64];
    shortint       inputs [16];
    logic [12:0]   hidden [16];
    bit            wt_ok [1024];
    bit            bias_ok [64];
    bit            in_ok [16];
    logic [12:0]   sig_tab [256];
    int unsigned   layer_reg;
    int unsigned   width_reg [5];
    mlpf_pkg::out_item_t expected_outputs [$];
    int            errors;

    function new();
      longint        mid;
      longint unsigned mag, e, den, num;
      for (int i = 0; i < 256; i++) begin
        mid = -32768 + longint'((longint'(2 * i + 1) * 65536) / 512);
        mag = (mid < 0) ? -mid : mid;
        e   = neg_exp_q30(mag);
        den = (64'd1 << 30) + e;
        num = (mid >= 0) ? (64'd1 << 30) : e;
        sig_tab[i] = 13'(((num << 12) + den / 2) / den);
      end
      layer_reg = 1;
      foreach (width_reg[i]) width_reg[i] = 1;
      errors = 0;
    endfunction

    // exp(-x/4096) in q30: taylor at x/2^20 then squared eight times
    function longint unsigned neg_exp_q30(longint unsigned x);
      longint unsigned a, a2, a3, a4, r;
      a  = x << 10;
      a2 = (a * a) >> 30;
      a3 = (a2 * a) >> 30;
      a4 = (a3 * a) >> 30;
      r  = (64'd1 << 30) - a + a2 / 2 - a3 / 6 + a4 / 24;
      repeat (8) r = (r * r) >> 30;
      return r;
    endfunction

    function int unsigned clamp_w(int unsigned v);
      return (v < 1) ? 1 : ((v > 16) ? 16 : v);
    endfunction

    function int unsigned layers_used();
      return (layer_reg < 1) ? 1 : ((layer_reg > 4) ? 4 : layer_reg);
    endfunction

    function void set_reg(int unsigned idx, int unsigned data);
      if (idx == mlpf_pkg::CFG_LAYER_COUNT) layer_reg = data & 7;
      else if (idx <= mlpf_pkg::CFG_WIDTH_L4) width_reg[idx - 1] = data & 31;
    endfunction

    function void note_item(mlpf_pkg::in_item_t it);
      int unsigned nl, prev_w, cur_w;
      longint      acc, s;
      logic [12:0] nxt [16];
      case (mlpf_pkg::cmd_op_e'(it.opcode))
        mlpf_pkg::OP_LOAD_W: begin
          wts[{it.layer_sel, it.row_sel, it.col_sel}] = it.load_value;
          wt_ok[{it.layer_sel, it.row_sel, it.col_sel}] = 1;
        end
        mlpf_pkg::OP_LOAD_B: begin
          biases[{it.layer_sel, it.col_sel}] = it.load_value;
          bias_ok[{it.layer_sel, it.col_sel}] = 1;
        end
        mlpf_pkg::OP_LOAD_A: begin
          inputs[it.col_sel] = it.load_value;
          in_ok[it.col_sel] = 1;
        end
        default: begin
          nl = layers_used();
          cur_w = 1;
          for (int l = 0; l < nl; l++) begin
            prev_w = clamp_w(width_reg[l]);
            cur_w  = clamp_w(width_reg[l + 1]);
            for (int j = 0; j < cur_w; j++) begin
              acc = longint'(biases[l * 16 + j]) * 4096;
              for (int k = 0; k < prev_w; k++)
                acc += ((l == 0) ? longint'(inputs[k]) : longint'(hidden[k]))
                       * longint'(wts[(l * 16 + k) * 16 + j]);
              s = acc >>> 12;   // floor division
              if (s < -32768) s = -32768;
              if (s > 32767) s = 32767;
              nxt[j] = sig_tab[(s + 32768) >> 8];
            end
            for (int j = 0; j < cur_w; j++) hidden[j] = nxt[j];
          end
          for (int j = 0; j < cur_w; j++)
            expected_outputs.push_back({4'(j), hidden[j], j == cur_w - 1});
        end
      endcase
    endfunction

    function void check_output(mlpf_pkg::out_item_t got);
      mlpf_pkg::out_item_t want;
      if (expected_outputs.size() == 0) begin
        $error("unexpected output item index=%0d value=%0d", got.out_index, got.out_value);
        errors++;
        return;
      end
      want = expected_outputs.pop_front();
      if (got.out_index !== want.out_index) begin
        $error("out_index expected %0d actual %0d", want.out_index, got.out_index);
        errors++;
      end
      if (got.out_value !== want.out_value) begin
        $error("out_value expected %0d actual %0d", want.out_value, got.out_value);
        errors++;
      end
      if (got.out_last !== want.out_last) begin
        $error("out_last expected %0d actual %0d", want.out_last, got.out_last);
        errors++;
      end
    endfunction
  endclass

  logic                                 clk;
  logic                                 rst_n;
  logic                                 in_valid;
  logic                                 in_stall;
  mlpf_pkg::in_item_t                   in_item;
  logic                                 out_valid;
  logic                                 out_stall;
  mlpf_pkg::out_item_t                  out_item;
  logic                                 cfg_we;
  logic [mlpf_pkg::CFG_IDX_W-1:0]       cfg_idx;
  logic [mlpf_pkg::CFG_DATA_W-1:0]      cfg_data;

  forward_pass_model net = new();
  bit                quiet;        // no idling on either side in this phase
  int unsigned       stall_left;
  int unsigned       cycles;

  mlp_sigmoid_forward uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // watchdog, generous against the slowest legal run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 1000000) begin
      $display("tb_mlp_sigmoid_forward NOT OK");
      $finish;
    end
  end

  // output side: check each accepted item, then draw a new stall length
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        net.check_output(out_item);
        stall_left = quiet ? 0 : $urandom_range(0, 9);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  function automatic mlpf_pkg::in_item_t mk_item(mlpf_pkg::cmd_op_e op, int unsigned lay,
                                                 int unsigned row, int unsigned col,
                                                 logic [15:0] val);
    mlpf_pkg::in_item_t it;
    it.opcode     = op;
    it.layer_sel  = lay[1:0];
    it.row_sel    = row[3:0];
    it.col_sel    = col[3:0];
    it.load_value = val;
    return it;
  endfunction

  // mostly modest magnitudes so sums stay off the rails, sometimes anything
  function automatic logic [15:0] rand_word();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 4095) - 2048);
  endfunction

  task automatic send_item(mlpf_pkg::in_item_t it);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    net.note_item(it);
  endtask

  task automatic send_run();
    send_item(mk_item(mlpf_pkg::OP_RUN, $urandom, $urandom, $urandom, 16'($urandom)));
  endtask

  // drain outputs, then let queued loads retire before touching registers
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (net.expected_outputs.size() != 0) @(posedge clk);
    repeat (32) @(posedge clk);
  endtask

  task automatic write_regs(int unsigned lc, int unsigned w0, int unsigned w1,
                            int unsigned w2, int unsigned w3, int unsigned w4);
    int unsigned vals [6];
    vals = '{lc, w0, w1, w2, w3, w4};
    for (int i = 0; i < 6; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= mlpf_pkg::CFG_IDX_W'(i);
      cfg_data <= mlpf_pkg::CFG_DATA_W'(vals[i]);
      @(posedge clk);
      net.set_reg(i, vals[i]);
    end
    // indexes past the list are ignored by the block
    cfg_idx  <= 3'd6 + mlpf_pkg::CFG_IDX_W'($urandom_range(0, 1));
    cfg_data <= mlpf_pkg::CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // load every word the next run will read that was never written
  task automatic fill_unwritten();
    int unsigned nl, pw, cw;
    nl = net.layers_used();
    for (int k = 0; k < net.clamp_w(net.width_reg[0]); k++)
      if (!net.in_ok[k])
        send_item(mk_item(mlpf_pkg::OP_LOAD_A, $urandom, $urandom, k, rand_word()));
    for (int l = 0; l < nl; l++) begin
      pw = net.clamp_w(net.width_reg[l]);
      cw = net.clamp_w(net.width_reg[l + 1]);
      for (int j = 0; j < cw; j++) begin
        if (!net.bias_ok[l * 16 + j])
          send_item(mk_item(mlpf_pkg::OP_LOAD_B, l, $urandom, j, rand_word()));
        for (int k = 0; k < pw; k++)
          if (!net.wt_ok[(l * 16 + k) * 16 + j])
            send_item(mk_item(mlpf_pkg::OP_LOAD_W, l, k, j, rand_word()));
      end
    end
  endtask

  // any load anywhere in the stores, including beyond the configured widths
  task automatic send_noise_load();
    mlpf_pkg::cmd_op_e op;
    op = mlpf_pkg::cmd_op_e'($urandom_range(0, 2));
    send_item(mk_item(op, $urandom, $urandom, $urandom, rand_word()));
  endtask

  // small widths keep the fills short; zero checks the low clamp
  function automatic int unsigned draw_width();
    if ($urandom_range(0, 7) == 0) return 0;
    return $urandom_range(1, 4);
  endfunction

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    cfg_we   = 1'b0;
    cfg_idx  = '0;
    cfg_data = '0;
    quiet    = 1'b0;
    cycles   = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: single neuron at reset widths, rails of the q3.12 range
    send_item(mk_item(mlpf_pkg::OP_LOAD_A, 0, 0, 0, 16'sh7fff));
    send_item(mk_item(mlpf_pkg::OP_LOAD_W, 0, 0, 0, 16'sh7fff));
    send_item(mk_item(mlpf_pkg::OP_LOAD_B, 0, 0, 0, 16'sh7fff));
    send_run();                                         // saturates high
    send_item(mk_item(mlpf_pkg::OP_LOAD_A, 0, 0, 0, 16'sh8000));
    send_item(mk_item(mlpf_pkg::OP_LOAD_B, 0, 0, 0, 16'sh8000));
    send_run();                                         // saturates low
    send_item(mk_item(mlpf_pkg::OP_LOAD_W, 0, 0, 0, 16'sh0000));
    send_item(mk_item(mlpf_pkg::OP_LOAD_B, 0, 0, 0, 16'sh0000));
    send_run();                                         // sigmoid of zero
    send_item(mk_item(mlpf_pkg::OP_LOAD_B, 0, 0, 0, 16'shffff));
    send_run();                                         // just below zero
    // load beyond the configured widths is kept
    send_item(mk_item(mlpf_pkg::OP_LOAD_W, 3, 15, 15, 16'sh1234));
    wait_idle();

    // registers out of range clamp: zero and over-the-top values
    write_regs(0, 0, 31, 17, 0, 20);
    fill_unwritten();
    send_run();
    wait_idle();
    write_regs(7, 2, 3, 1, 2, 3);
    fill_unwritten();
    send_run();
    wait_idle();

    // widest input and widest output layer, all four layers in use
    write_regs(4, 16, 1, 1, 1, 16);
    fill_unwritten();
    send_run();
    send_run();
    wait_idle();

    // random phases: register setting, fill, then runs mixed with loads
    for (int ph = 0; ph < 16; ph++) begin
      quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0)
        write_regs(1, 1, 1, 1, 1, 1);
      else
        write_regs(($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4),
                   draw_width(), draw_width(), draw_width(), draw_width(), draw_width());
      fill_unwritten();
      repeat ($urandom_range(0, 3)) send_noise_load();
      repeat ($urandom_range(1, 3)) begin
        send_run();
        repeat ($urandom_range(0, 2)) send_noise_load();
        // in phase five, hold off until every output has come back
        if (ph == 5) begin
          in_valid <= 1'b0;
          while (net.expected_outputs.size() != 0) @(posedge clk);
        end
      end
      wait_idle();
    end

    while (net.expected_outputs.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (net.errors == 0)
      $display("tb_mlp_sigmoid_forward OK");
    else
      $display("tb_mlp_sigmoid_forward NOT OK");
    $finish;
  end

endmodule
